/* rtl/memory_block_mix_hash_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the memory block mix hash
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MEMORY_BLOCK_MIX_HASH_DEFINES_SVH
`define MEMORY_BLOCK_MIX_HASH_DEFINES_SVH

// Same-cycle implication, disabled while the reset is applied.
`define MBMH_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("mbmh check failed");

// Next-cycle implication, disabled while the reset is applied.
`define MBMH_ASSERT_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("mbmh check failed");

`endif

/* rtl/mbmh_pkg.sv */
// ----------------------------------------------------------------------------
// mbmh_pkg
// Types, constants and helper functions of the memory block mix hash.
// ----------------------------------------------------------------------------
package mbmh_pkg;

   localparam int MEM_WORDS = 65536;
   localparam int ADDR_W    = $clog2(MEM_WORDS);
   // Range checks are done in a width that holds any address plus a block.
   localparam int CHK_W     = ((ADDR_W > 16) ? ADDR_W : 16) + 2;

   localparam int WORD_W    = 32;
   localparam int LANES     = 8;
   localparam int ROT_LEFT  = 7;
   localparam int ROT_RIGHT = 25;

   localparam logic [12:0] BW_MIN   = 13'd8;
   localparam logic [12:0] BW_MAX   = 13'd4096;
   localparam logic [12:0] BW_RESET = 13'd1024;
   localparam logic [12:0] SW_RESET = 13'd1024;
   localparam logic [7:0]  REP_RESET = 8'd1;

   localparam logic [1:0] CSR_BLOCK_WORDS     = 2'd0;
   localparam logic [1:0] CSR_SUB_BLOCK_WORDS = 2'd1;
   localparam logic [1:0] CSR_REPETITIONS     = 2'd2;

   localparam logic ST_OK      = 1'b0;
   localparam logic ST_IGNORED = 1'b1;

   typedef logic [ADDR_W-1:0] mem_addr_type;
   typedef logic [CHK_W-1:0]  chk_type;
   typedef logic [15:0]       word_addr_type;
   typedef logic [11:0]       word_idx_type;
   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [2:0] {
      CMD_WRITE_WORD = 3'd0,
      CMD_READ_WORD  = 3'd1,
      CMD_SET_LANE   = 3'd2,
      CMD_READ_LANE  = 3'd3,
      CMD_HASH       = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RD_WAIT,
      S_RD_FROM,
      S_RD_PREV,
      S_WRITE
   } state_type;

   function automatic logic is_pow2_between(input logic [12:0] v,
                                            input logic [12:0] lo,
                                            input logic [12:0] hi);
      return (v >= lo) && (v <= hi) && ((v & (v - 13'd1)) == 13'd0);
   endfunction

   function automatic logic [3:0] log2_13(input logic [12:0] v);
      logic [3:0] r;
      r = 4'd0;
      for (int i = 0; i < 13; i++) begin
         if (v[i]) begin
            r = 4'(i);
         end
      end
      return r;
   endfunction

   function automatic word_type rotl7(input word_type x);
      return {x[WORD_W-1-ROT_LEFT:0], x[WORD_W-1:ROT_RIGHT]};
   endfunction

endpackage

/* rtl/memory_block_mix_hash.sv */
// ----------------------------------------------------------------------------
// memory_block_mix_hash
// Memory-hard block mixer over a single-port word memory and eight lanes.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its fields are
// latched at that edge. Each request produces exactly one response, shown for
// one cycle with rsp_valid high; the receiver cannot stall it.
// Write word, set lane, read lane, unused codes, out-of-range reads,
// rejected hashes and hashes of zero repetitions respond from S_EXEC; an
// in-range read word waits in S_RD_WAIT for the registered memory read;
// any other hash responds with its last destination write.
// Every hashed word takes three steps on the single memory port: read the
// from word, read the previous-block word, write the destination word.
// busy drops in the cycle the response is shown, so the next request may be
// accepted then. Configuration is written through csr_we/csr_addr/csr_wdata;
// the user must do so while the block is idle; the block does not enforce it.
// Reset sets all lanes to one and the registers to 1024, 1024 and 1; the word
// memory is not cleared and holds nothing defined until written.
// ----------------------------------------------------------------------------
module memory_block_mix_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [15:0] req_word_addr,
   input  logic [2:0]  req_lane_index,
   input  logic [31:0] req_write_data,
   input  logic [15:0] req_source_addr,
   input  logic [15:0] req_dest_addr,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_data,
   output logic        rsp_status,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [12:0] csr_wdata
);

   mbmh_pkg::state_type state_ff, state_in;

   logic [12:0] bw_ff, sw_ff;
   logic [7:0]  reps_ff;

   logic [2:0]              cmd_ff, cmd_in;
   mbmh_pkg::word_addr_type waddr_ff, waddr_in;
   logic [2:0]              lane_idx_ff, lane_idx_in;
   mbmh_pkg::word_type      wdata_ff, wdata_in;
   mbmh_pkg::word_addr_type src_ff, src_in;
   mbmh_pkg::word_addr_type dst_ff, dst_in;

   mbmh_pkg::word_addr_type prev_base_ff, prev_base_in;
   mbmh_pkg::word_addr_type ptr_ff, ptr_in;
   logic [3:0]              sh_ff, sh_in;
   logic [12:0]             mask_ff, mask_in;
   mbmh_pkg::word_idx_type  k_ff, k_in;
   mbmh_pkg::word_idx_type  w_ff, w_in;
   logic [7:0]              rep_ff, rep_in;
   mbmh_pkg::word_type      from_word_ff, from_word_in;

   mbmh_pkg::word_type lane_ff [mbmh_pkg::LANES];
   mbmh_pkg::word_type lane_in [mbmh_pkg::LANES];

   logic               rsp_valid_ff, rsp_valid_in;
   mbmh_pkg::word_type rsp_data_ff, rsp_data_in;
   logic               rsp_status_ff, rsp_status_in;

   logic                   ram_we;
   mbmh_pkg::mem_addr_type ram_addr;
   mbmh_pkg::word_type     ram_wdata;
   mbmh_pkg::word_type     ram_rdata;

   logic                    addr_ok, cfg_ok, range_ok, hash_bad;
   logic                    last_word, last_rep, sub_end;
   logic [12:0]             bw_less1, sw_less1, sel;
   logic [3:0]              sh_calc;
   mbmh_pkg::word_addr_type prev_addr;
   mbmh_pkg::word_type      mix_sum, lane_new;

   mbmh_ram #(
      .WIDTH (mbmh_pkg::WORD_W),
      .DEPTH (mbmh_pkg::MEM_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Checks on the latched request and the configuration.
   assign addr_ok = mbmh_pkg::chk_type'(waddr_ff) < mbmh_pkg::chk_type'(mbmh_pkg::MEM_WORDS);
   assign cfg_ok  = mbmh_pkg::is_pow2_between(bw_ff, mbmh_pkg::BW_MIN, mbmh_pkg::BW_MAX) &&
                    mbmh_pkg::is_pow2_between(sw_ff, mbmh_pkg::BW_MIN, bw_ff);
   assign range_ok =
      (mbmh_pkg::chk_type'(src_ff) + mbmh_pkg::chk_type'(bw_ff) <=
       mbmh_pkg::chk_type'(mbmh_pkg::MEM_WORDS)) &&
      (mbmh_pkg::chk_type'(dst_ff) >= mbmh_pkg::chk_type'(bw_ff)) &&
      (mbmh_pkg::chk_type'(dst_ff) + mbmh_pkg::chk_type'(bw_ff) <=
       mbmh_pkg::chk_type'(mbmh_pkg::MEM_WORDS));
   assign hash_bad = !(cfg_ok && range_ok);
   assign sh_calc  = mbmh_pkg::log2_13(sw_ff);

   assign bw_less1  = bw_ff - 13'd1;
   assign sw_less1  = (13'd1 << sh_ff) - 13'd1;
   assign last_word = (k_ff == bw_less1[11:0]);
   assign last_rep  = (rep_ff == (reps_ff - 8'd1));
   assign sub_end   = (w_ff == sw_less1[11:0]);

   // The first from word of a sub-block picks the previous-block sub-block.
   assign sel       = ram_rdata[12:0] & mask_ff;
   assign prev_addr = (w_ff == '0) ?
                      prev_base_ff + (mbmh_pkg::word_addr_type'(sel) << sh_ff) : ptr_ff;

   assign mix_sum  = lane_ff[k_ff[2:0]] + ram_rdata;
   assign lane_new = mbmh_pkg::rotl7(mix_sum ^ from_word_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mbmh_pkg::S_IDLE: begin
            if (start) begin
               state_in = mbmh_pkg::S_EXEC;
            end
         end
         mbmh_pkg::S_EXEC: begin
            state_in = mbmh_pkg::S_IDLE;
            if (cmd_ff == mbmh_pkg::CMD_READ_WORD && addr_ok) begin
               state_in = mbmh_pkg::S_RD_WAIT;
            end else if (cmd_ff == mbmh_pkg::CMD_HASH && !hash_bad && reps_ff != 8'd0) begin
               state_in = mbmh_pkg::S_RD_FROM;
            end
         end
         mbmh_pkg::S_RD_WAIT: state_in = mbmh_pkg::S_IDLE;
         mbmh_pkg::S_RD_FROM: state_in = mbmh_pkg::S_RD_PREV;
         mbmh_pkg::S_RD_PREV: state_in = mbmh_pkg::S_WRITE;
         mbmh_pkg::S_WRITE: begin
            state_in = (last_word && last_rep) ? mbmh_pkg::S_IDLE : mbmh_pkg::S_RD_FROM;
         end
         default: state_in = mbmh_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd_in       = cmd_ff;
      waddr_in     = waddr_ff;
      lane_idx_in  = lane_idx_ff;
      wdata_in     = wdata_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      prev_base_in = prev_base_ff;
      ptr_in       = ptr_ff;
      sh_in        = sh_ff;
      mask_in      = mask_ff;
      k_in         = k_ff;
      w_in         = w_ff;
      rep_in       = rep_ff;
      from_word_in = from_word_ff;
      lane_in      = lane_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      ram_we    = 1'b0;
      ram_addr  = mbmh_pkg::mem_addr_type'(waddr_ff);
      ram_wdata = wdata_ff;

      case (state_ff)
         mbmh_pkg::S_IDLE: begin
            if (start) begin
               cmd_in      = req_cmd;
               waddr_in    = req_word_addr;
               lane_idx_in = req_lane_index;
               wdata_in    = req_write_data;
               src_in      = req_source_addr;
               dst_in      = req_dest_addr;
            end
         end
         mbmh_pkg::S_EXEC: begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = '0;
            rsp_status_in = mbmh_pkg::ST_OK;
            case (cmd_ff)
               mbmh_pkg::CMD_WRITE_WORD: begin
                  ram_we        = addr_ok;
                  rsp_status_in = addr_ok ? mbmh_pkg::ST_OK : mbmh_pkg::ST_IGNORED;
               end
               mbmh_pkg::CMD_READ_WORD: begin
                  rsp_valid_in  = !addr_ok;
                  rsp_status_in = mbmh_pkg::ST_IGNORED;
               end
               mbmh_pkg::CMD_SET_LANE: begin
                  lane_in[lane_idx_ff] = wdata_ff;
               end
               mbmh_pkg::CMD_READ_LANE: begin
                  rsp_data_in = lane_ff[lane_idx_ff];
               end
               mbmh_pkg::CMD_HASH: begin
                  if (hash_bad) begin
                     rsp_status_in = mbmh_pkg::ST_IGNORED;
                  end else if (reps_ff != 8'd0) begin
                     rsp_valid_in = 1'b0;
                     k_in         = '0;
                     w_in         = '0;
                     rep_in       = '0;
                     sh_in        = sh_calc;
                     mask_in      = (bw_ff >> sh_calc) - 13'd1;
                     prev_base_in = dst_ff - mbmh_pkg::word_addr_type'(bw_ff);
                  end
               end
               default: begin
               end
            endcase
         end
         mbmh_pkg::S_RD_WAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = ram_rdata;
            rsp_status_in = mbmh_pkg::ST_OK;
         end
         mbmh_pkg::S_RD_FROM: begin
            ram_addr = mbmh_pkg::mem_addr_type'(src_ff + mbmh_pkg::word_addr_type'(k_ff));
         end
         mbmh_pkg::S_RD_PREV: begin
            from_word_in = ram_rdata;
            ram_addr     = mbmh_pkg::mem_addr_type'(prev_addr);
            ptr_in       = prev_addr + 16'd1;
         end
         mbmh_pkg::S_WRITE: begin
            ram_we    = 1'b1;
            ram_addr  = mbmh_pkg::mem_addr_type'(dst_ff + mbmh_pkg::word_addr_type'(k_ff));
            ram_wdata = lane_new;
            lane_in[k_ff[2:0]] = lane_new;
            if (last_word) begin
               k_in   = '0;
               w_in   = '0;
               rep_in = rep_ff + 8'd1;
               if (last_rep) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = '0;
                  rsp_status_in = mbmh_pkg::ST_OK;
               end
            end else begin
               k_in = k_ff + 12'd1;
               w_in = sub_end ? '0 : w_ff + 12'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbmh_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         bw_ff        <= mbmh_pkg::BW_RESET;
         sw_ff        <= mbmh_pkg::SW_RESET;
         reps_ff      <= mbmh_pkg::REP_RESET;
         k_ff         <= '0;
         w_ff         <= '0;
         rep_ff       <= '0;
         for (int i = 0; i < mbmh_pkg::LANES; i++) begin
            lane_ff[i] <= mbmh_pkg::word_type'(1);
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         w_ff         <= w_in;
         rep_ff       <= rep_in;
         lane_ff      <= lane_in;
         if (csr_we) begin
            case (csr_addr)
               mbmh_pkg::CSR_BLOCK_WORDS:     bw_ff   <= csr_wdata;
               mbmh_pkg::CSR_SUB_BLOCK_WORDS: sw_ff   <= csr_wdata;
               mbmh_pkg::CSR_REPETITIONS:     reps_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      waddr_ff      <= waddr_in;
      lane_idx_ff   <= lane_idx_in;
      wdata_ff      <= wdata_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      prev_base_ff  <= prev_base_in;
      ptr_ff        <= ptr_in;
      sh_ff         <= sh_in;
      mask_ff       <= mask_in;
      from_word_ff  <= from_word_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy          = (state_ff != mbmh_pkg::S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

/* rtl/mbmh_ram.sv */
// ----------------------------------------------------------------------------
// mbmh_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mbmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/mbmh_checker.sv */
// ----------------------------------------------------------------------------
// mbmh_checker
// Port-level checks of the request and response timing of the mixer.
// ----------------------------------------------------------------------------
`include "memory_block_mix_hash_defines.svh"

module mbmh_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_read_data,
   input logic        rsp_status
);

   // An accepted request keeps the block busy until its response.
   `MBMH_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)

   // The response comes out as the block goes idle.
   `MBMH_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)

   // A response strobe lasts one cycle.
   `MBMH_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)

   // Going idle always delivers a response.
   `MBMH_ASSERT_IMP(a_idle_rsp, clock, reset, !$past(reset) && $fell(busy), rsp_valid)

   // An ignored request reads back nothing.
   `MBMH_ASSERT_IMP(a_ignored_zero, clock, reset, rsp_valid && rsp_status, rsp_read_data == 32'd0)

endmodule

bind memory_block_mix_hash mbmh_checker u_mbmh_checker (.*);
